### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the digit rank and unrank unit.
// No dependencies; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst, a, c)
`define ASSERT_NEXT(lbl, clk, rst, a, c)
`endif
`endif

### rtl/ddru_pkg.sv
// Types and constants of the digit rank and unrank unit.
// No dependencies; used by digit_dominated_rank_unrank_unit and its testbench.
`timescale 1ns / 1ps
package ddru_pkg;
   localparam int CNT_W = 7;
   localparam int WORD_W = 64;
   localparam int BASE_W = 32;
   localparam int MPL_W = 33;

   localparam logic [1:0] MODE_RANK = 2'd0;
   localparam logic [1:0] MODE_UNRANK = 2'd1;
   localparam logic [1:0] MODE_SUCC = 2'd2;

   localparam logic [1:0] REG_BASE = 2'd0;
   localparam logic [1:0] REG_LIMIT = 2'd1;

   typedef enum logic [1:0] {
      JOB_RB = 2'd0,
      JOB_SCAN = 2'd1,
      JOB_UNR = 2'd2,
      JOB_SUCC = 2'd3
   } job_type;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_LOAD = 7'b0000010,
      ST_DIV = 7'b0000100,
      ST_EVAL = 7'b0001000,
      ST_MUL = 7'b0010000,
      ST_POST = 7'b0100000,
      ST_NEXT = 7'b1000000
   } state_type;
endpackage

### rtl/digit_dominated_rank_unrank_unit.sv
// Top level of the digit rank, unrank and successor unit.
// Depends on ddru_pkg and assert_macros.svh.
`timescale 1ns / 1ps
// The unit holds a base p and a limit q, written through the csr_ port (index 0 base,
// index 1 limit). Every such write, and reset, starts a rebuild that splits q into
// base-p digits and stores the digit weights; busy is high during it. An item is
// taken when start is high, busy is low and no csr_ write comes in that cycle.
// Per item, each digit step runs a bit-serial divider and, where needed, a shift-add
// multiplier. Rank multiplies at every digit; unrank multiplies at every digit and
// then scans the digits; successor and the unused mode only scan, successor then
// adding a multiply per power of p. The result appears on the rsp_ ports for one
// cycle with rsp_strobe high, and busy falls in the same cycle, so the next item may
// be started at once. The receiver cannot stall the unit. After reset the unit acts
// as base 2 and limit 0.
module digit_dominated_rank_unrank_unit #(
   parameter int MAX_DIGITS = 64
) (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_mode,
   input logic [ddru_pkg::WORD_W-1:0] req_operand,
   output logic rsp_strobe,
   output logic [ddru_pkg::WORD_W-1:0] rsp_answer,
   output logic [ddru_pkg::CNT_W-1:0] rsp_deficient_position,
   output logic [ddru_pkg::WORD_W-1:0] rsp_interval_total,
   output logic rsp_overflow,
   input logic csr_we,
   input logic [1:0] csr_index,
   input logic [ddru_pkg::WORD_W-1:0] csr_data
);
   import ddru_pkg::*;
`include "assert_macros.svh"

   localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DIGITS);

   state_type state_ff, state_in;
   job_type job_ff, job_in;
   logic unr_sub_ff, unr_sub_in, from_unr_ff, from_unr_in;
   logic [1:0] mode_ff, mode_in;
   logic [BASE_W-1:0] base_ff, base_in;
   logic [WORD_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, idx_ff, idx_in, pos_ff, pos_in;
   logic [WORD_W-1:0] total_ff, total_in, wcur_ff, wcur_in, cur_ff, cur_in;
   logic [WORD_W-1:0] higher_ff, higher_in, sum_ff, sum_in, place_ff, place_in;
   logic found_ff, found_in, ovf_ff, ovf_in;
   logic [WORD_W-1:0] dq_ff, dq_in;
   logic [MPL_W-1:0] dr_ff, dr_in;
   logic [5:0] dcnt_ff, dcnt_in, mcnt_ff, mcnt_in;
   logic [WORD_W-1:0] pr_ff, pr_in, mc_ff, mc_in;
   logic pov_ff, pov_in;
   logic [MPL_W-1:0] mp_ff, mp_in;
   logic strobe_ff, strobe_in, rovf_ff, rovf_in;
   logic [WORD_W-1:0] rans_ff, rans_in, rtot_ff, rtot_in;
   logic [CNT_W-1:0] rpos_ff, rpos_in;

   logic [BASE_W-1:0] dig_mem [MAX_DIGITS];
   logic [WORD_W-1:0] wt_mem [MAX_DIGITS];
   logic [BASE_W-1:0] dig_rd_ff;
   logic [WORD_W-1:0] wt_rd_ff;
   logic mem_we;

   logic [BASE_W-1:0] eff_p;
   logic [MPL_W-1:0] dsor;
   logic [MPL_W:0] r2, r2s;
   logic ge;
   logic [WORD_W-1:0] addend;
   logic [WORD_W:0] msum, rsum, hplus;
   logic [CNT_W-1:0] idx1, posv;
   logic [WORD_W-1:0] hv, ans_fin;

   always_comb begin
      eff_p = (base_ff < BASE_W'(2)) ? BASE_W'(2) : base_ff;
      dsor = (job_ff == JOB_UNR) ? ({1'b0, dig_rd_ff} + MPL_W'(1)) : {1'b0, eff_p};
      r2 = {dr_ff, dq_ff[WORD_W-1]};
      r2s = r2 - {1'b0, dsor};
      ge = r2 >= {1'b0, dsor};
      addend = mp_ff[MPL_W-1] ? mc_ff : '0;
      msum = {1'b0, pr_ff[WORD_W-2:0], 1'b0} + {1'b0, addend};
      rsum = {1'b0, sum_ff} + {1'b0, pr_ff};
      idx1 = idx_ff + CNT_W'(1);
      posv = found_ff ? pos_ff : cnt_ff;
      hv = found_ff ? higher_ff : cur_ff;
      hplus = {1'b0, hv} + (WORD_W+1)'(1);
      if (from_unr_ff || mode_ff == MODE_RANK) begin
         ans_fin = sum_ff;
      end else if (mode_ff == MODE_SUCC) begin
         ans_fin = hplus[WORD_W-1:0];
      end else begin
         ans_fin = '0;
      end
   end

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      unr_sub_in = unr_sub_ff;
      from_unr_in = from_unr_ff;
      mode_in = mode_ff;
      base_in = base_ff;
      limit_in = limit_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      pos_in = pos_ff;
      total_in = total_ff;
      wcur_in = wcur_ff;
      cur_in = cur_ff;
      higher_in = higher_ff;
      sum_in = sum_ff;
      place_in = place_ff;
      found_in = found_ff;
      ovf_in = ovf_ff;
      dq_in = dq_ff;
      dr_in = dr_ff;
      dcnt_in = dcnt_ff;
      mcnt_in = mcnt_ff;
      pr_in = pr_ff;
      mc_in = mc_ff;
      pov_in = pov_ff;
      mp_in = mp_ff;
      strobe_in = 1'b0;
      rans_in = rans_ff;
      rtot_in = rtot_ff;
      rpos_in = rpos_ff;
      rovf_in = rovf_ff;
      mem_we = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               mode_in = req_mode;
               cur_in = req_operand;
               idx_in = '0;
               found_in = 1'b0;
               sum_in = '0;
               ovf_in = 1'b0;
               from_unr_in = 1'b0;
               unr_sub_in = 1'b0;
               place_in = WORD_W'(1);
               job_in = (req_mode == MODE_UNRANK) ? JOB_UNR : JOB_SCAN;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            dq_in = cur_ff;
            dr_in = '0;
            dcnt_in = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dq_in = {dq_ff[WORD_W-2:0], ge};
            dr_in = ge ? r2s[MPL_W-1:0] : r2[MPL_W-1:0];
            dcnt_in = dcnt_ff + 6'd1;
            if (dcnt_ff == 6'd63) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            cur_in = dq_ff;
            pr_in = '0;
            pov_in = 1'b0;
            mcnt_in = '0;
            state_in = ST_MUL;
            case (job_ff)
               JOB_RB: begin
                  mem_we = 1'b1;
                  mc_in = wcur_ff;
                  mp_in = dr_ff + MPL_W'(1);
               end
               JOB_UNR: begin
                  mc_in = place_ff;
                  mp_in = dr_ff;
               end
               default: begin
                  if (!found_ff && ({1'b0, dig_rd_ff} > dr_ff)) begin
                     found_in = 1'b1;
                     pos_in = idx_ff;
                     higher_in = cur_ff;
                  end
                  mc_in = wt_rd_ff;
                  mp_in = dr_ff;
                  if (from_unr_ff || mode_ff != MODE_RANK) begin
                     state_in = ST_NEXT;
                  end
               end
            endcase
         end
         ST_MUL: begin
            pr_in = msum[WORD_W-1:0];
            pov_in = pov_ff | pr_ff[WORD_W-1] | msum[WORD_W];
            mp_in = {mp_ff[MPL_W-2:0], 1'b0};
            mcnt_in = mcnt_ff + 6'd1;
            if (mcnt_ff == 6'(MPL_W - 1)) begin
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            state_in = ST_NEXT;
            case (job_ff)
               JOB_RB: begin
                  wcur_in = pr_ff;
               end
               JOB_SCAN: begin
                  sum_in = rsum[WORD_W-1:0];
                  ovf_in = ovf_ff | pov_ff | rsum[WORD_W];
               end
               JOB_UNR: begin
                  if (!unr_sub_ff) begin
                     sum_in = rsum[WORD_W-1:0];
                     unr_sub_in = 1'b1;
                     mc_in = place_ff;
                     mp_in = {1'b0, eff_p};
                     pr_in = '0;
                     pov_in = 1'b0;
                     mcnt_in = '0;
                     state_in = ST_MUL;
                  end else begin
                     place_in = pr_ff;
                     unr_sub_in = 1'b0;
                  end
               end
               default: begin
                  sum_in = pr_ff;
                  ovf_in = ovf_ff | pov_ff;
                  if (idx1 < pos_ff) begin
                     idx_in = idx1;
                     mc_in = pr_ff;
                     mp_in = {1'b0, eff_p};
                     pr_in = '0;
                     pov_in = 1'b0;
                     mcnt_in = '0;
                     state_in = ST_MUL;
                  end else begin
                     strobe_in = 1'b1;
                     rans_in = pr_ff;
                     rovf_in = ovf_ff | pov_ff;
                     rpos_in = pos_ff;
                     rtot_in = total_ff;
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         ST_NEXT: begin
            case (job_ff)
               JOB_RB: begin
                  if (cur_ff != '0 && idx1 < MAX_CNT) begin
                     idx_in = idx1;
                     state_in = ST_LOAD;
                  end else begin
                     cnt_in = idx1;
                     total_in = wcur_ff - WORD_W'(1);
                     state_in = ST_IDLE;
                  end
               end
               JOB_UNR: begin
                  state_in = ST_LOAD;
                  if (idx1 < cnt_ff) begin
                     idx_in = idx1;
                  end else begin
                     cur_in = sum_ff;
                     idx_in = '0;
                     found_in = 1'b0;
                     from_unr_in = 1'b1;
                     job_in = JOB_SCAN;
                  end
               end
               default: begin
                  if (idx1 < cnt_ff) begin
                     idx_in = idx1;
                     state_in = ST_LOAD;
                  end else if (!from_unr_ff && mode_ff == MODE_SUCC
                               && posv != '0) begin
                     pos_in = posv;
                     ovf_in = hplus[WORD_W];
                     idx_in = '0;
                     job_in = JOB_SUCC;
                     mc_in = hplus[WORD_W-1:0];
                     mp_in = {1'b0, eff_p};
                     pr_in = '0;
                     pov_in = 1'b0;
                     mcnt_in = '0;
                     state_in = ST_MUL;
                  end else begin
                     strobe_in = 1'b1;
                     rans_in = ans_fin;
                     rpos_in = posv;
                     rtot_in = total_ff;
                     if (from_unr_ff) begin
                        rovf_in = 1'b0;
                     end else if (mode_ff == MODE_RANK) begin
                        rovf_in = ovf_ff;
                     end else if (mode_ff == MODE_SUCC) begin
                        rovf_in = hplus[WORD_W];
                     end else begin
                        rovf_in = 1'b0;
                     end
                     state_in = ST_IDLE;
                  end
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we && (csr_index == REG_BASE || csr_index == REG_LIMIT)) begin
         if (csr_index == REG_BASE) begin
            base_in = csr_data[BASE_W-1:0];
            cur_in = limit_ff;
         end else begin
            limit_in = csr_data;
            cur_in = csr_data;
         end
         wcur_in = WORD_W'(1);
         idx_in = '0;
         job_in = JOB_RB;
         strobe_in = 1'b0;
         state_in = ST_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dig_mem[idx_ff[IDX_W-1:0]] <= dr_ff[BASE_W-1:0];
         wt_mem[idx_ff[IDX_W-1:0]] <= wcur_ff;
      end
      dig_rd_ff <= dig_mem[idx_ff[IDX_W-1:0]];
      wt_rd_ff <= wt_mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         job_ff <= JOB_RB;
         base_ff <= BASE_W'(2);
         limit_ff <= '0;
         cur_ff <= '0;
         wcur_ff <= WORD_W'(1);
         idx_ff <= '0;
         cnt_ff <= CNT_W'(1);
         total_ff <= '0;
         strobe_ff <= 1'b0;
         unr_sub_ff <= 1'b0;
         from_unr_ff <= 1'b0;
         found_ff <= 1'b0;
         ovf_ff <= 1'b0;
         dcnt_ff <= '0;
         mcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         base_ff <= base_in;
         limit_ff <= limit_in;
         cur_ff <= cur_in;
         wcur_ff <= wcur_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
         total_ff <= total_in;
         strobe_ff <= strobe_in;
         unr_sub_ff <= unr_sub_in;
         from_unr_ff <= from_unr_in;
         found_ff <= found_in;
         ovf_ff <= ovf_in;
         dcnt_ff <= dcnt_in;
         mcnt_ff <= mcnt_in;
      end
      mode_ff <= mode_in;
      pos_ff <= pos_in;
      higher_ff <= higher_in;
      sum_ff <= sum_in;
      place_ff <= place_in;
      dq_ff <= dq_in;
      dr_ff <= dr_in;
      pr_ff <= pr_in;
      pov_ff <= pov_in;
      mc_ff <= mc_in;
      mp_ff <= mp_in;
      rans_ff <= rans_in;
      rtot_ff <= rtot_in;
      rpos_ff <= rpos_in;
      rovf_ff <= rovf_in;
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_answer = rans_ff;
   assign rsp_deficient_position = rpos_ff;
   assign rsp_interval_total = rtot_ff;
   assign rsp_overflow = rovf_ff;

   `ASSERT_NEXT(a_take_busy, clock, reset, start && !busy && !csr_we, busy)
   `ASSERT_NEXT(a_strobe_pulse, clock, reset, rsp_strobe, !rsp_strobe)
   `ASSERT_SAME(a_pos_range, clock, reset, rsp_strobe, rsp_deficient_position <= cnt_ff)
   `ASSERT_SAME(a_strobe_idle, clock, reset, rsp_strobe, !busy || $past(csr_we))
endmodule

### test/digit_dominated_rank_unrank_unit_test.sv
// Self-checking testbench of the digit rank, unrank and successor unit.
// Depends on ddru_pkg and digit_dominated_rank_unrank_unit; predicts every result itself.
`timescale 1ns / 1ps
module digit_dominated_rank_unrank_unit_test;
   import ddru_pkg::*;

   typedef struct {
      logic [1:0] mode;
      logic [WORD_W-1:0] operand;
   } digit_item_type;

   typedef struct {
      logic [WORD_W-1:0] answer;
      logic [CNT_W-1:0] position;
      logic [WORD_W-1:0] total;
      logic overflow;
   } digit_result_type;

   localparam int STALL_LIMIT = 200000;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_mode = MODE_RANK;
   logic [WORD_W-1:0] req_operand = '0;
   logic rsp_strobe;
   logic [WORD_W-1:0] rsp_answer;
   logic [CNT_W-1:0] rsp_deficient_position;
   logic [WORD_W-1:0] rsp_interval_total;
   logic rsp_overflow;
   logic csr_we = 0;
   logic [1:0] csr_index = REG_BASE;
   logic [WORD_W-1:0] csr_data = '0;

   digit_item_type pending_items[$];
   digit_result_type expected_results[$];
   int errors = 0;
   int accepted_count = 0;
   int stall_cycles = 0;

   logic [BASE_W-1:0] cfg_base;
   logic [WORD_W-1:0] cfg_limit;
   logic [31:0] limit_digit[64];
   logic [WORD_W-1:0] weight[64];
   int digit_total;
   logic [WORD_W-1:0] span_total;

   digit_dominated_rank_unrank_unit dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [WORD_W-1:0] radix_of();
      return (cfg_base < 2) ? 64'd2 : {32'd0, cfg_base};
   endfunction

   task automatic split_limit();
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] q;
      logic [WORD_W-1:0] w;
      p = radix_of();
      q = cfg_limit;
      w = 1;
      digit_total = 0;
      if (q == 0) begin
         limit_digit[0] = 0;
         digit_total = 1;
      end else begin
         while (q > 0 && digit_total < 64) begin
            limit_digit[digit_total] = 32'(q % p);
            q = q / p;
            digit_total++;
         end
      end
      for (int i = 0; i < digit_total; i++) begin
         weight[i] = w;
         w = w * ({32'd0, limit_digit[i]} + 64'd1);
      end
      span_total = w - 64'd1;
   endtask

   function automatic int first_short_digit(logic [WORD_W-1:0] j,
                                            output logic [WORD_W-1:0] higher);
      logic [WORD_W-1:0] p;
      p = radix_of();
      for (int i = 0; i < digit_total; i++) begin
         if (j % p < {32'd0, limit_digit[i]}) begin
            higher = j;
            return i;
         end
         j = j / p;
      end
      higher = j;
      return digit_total;
   endfunction

   function automatic digit_result_type predict_digits(logic [1:0] m, logic [WORD_W-1:0] x);
      digit_result_type r;
      logic [WORD_W-1:0] p;
      logic [WORD_W-1:0] k;
      logic [WORD_W-1:0] place;
      logic [WORD_W-1:0] radix;
      logic [WORD_W-1:0] higher;
      logic [WORD_W-1:0] hi;
      logic [WORD_W-1:0] lo;
      logic [127:0] prod;
      logic [127:0] sum;
      int pos;
      p = radix_of();
      r.answer = 0;
      r.overflow = 0;
      if (m == MODE_UNRANK) begin
         k = x;
         place = 1;
         for (int i = 0; i < digit_total; i++) begin
            radix = {32'd0, limit_digit[i]} + 64'd1;
            r.answer = r.answer + (k % radix) * place;
            k = k / radix;
            place = place * p;
         end
         pos = first_short_digit(r.answer, higher);
      end else begin
         pos = first_short_digit(x, higher);
         if (m == MODE_RANK) begin
            k = x;
            sum = 0;
            for (int i = 0; i < digit_total; i++) begin
               sum = sum + {64'd0, k % p} * {64'd0, weight[i]};
               k = k / p;
            end
            r.answer = sum[63:0];
            r.overflow = sum[127:64] != 0;
         end else if (m == MODE_SUCC) begin
            lo = higher + 64'd1;
            hi = (lo == 0) ? 64'd1 : 64'd0;
            for (int i = 0; i < pos; i++) begin
               prod = {64'd0, lo} * {64'd0, p};
               hi = hi * p + prod[127:64];
               lo = prod[63:0];
            end
            r.answer = lo;
            r.overflow = hi != 0;
         end
      end
      r.position = CNT_W'(pos);
      r.total = span_total;
      return r;
   endfunction

   task automatic report(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
      $display("mismatch on %s: got %h, expected %h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // Driver: holds an offered item until it is taken, then offers the next one.
   always @(posedge clock) begin
      logic fire;
      int idle_pct;
      fire = start && !busy;
      if (reset) begin
         start <= 0;
      end else begin
         if (fire) begin
            expected_results.insert(expected_results.size(),
                                    predict_digits(req_mode, req_operand));
            void'(pending_items.pop_front());
            accepted_count++;
         end
         idle_pct = (accepted_count < 55) ? 35 : (accepted_count < 110) ? 56 : 0;
         if (start && !fire) begin
            start <= 1;
         end else if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
            start <= 1;
            req_mode <= pending_items[0].mode;
            req_operand <= pending_items[0].operand;
         end else begin
            start <= 0;
         end
      end
   end

   // Monitor: every strobed result is checked against the oldest prediction.
   always @(posedge clock) begin
      digit_result_type want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            report("unexpected item", rsp_answer, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_answer !== want.answer) report("answer", rsp_answer, want.answer);
            if (rsp_deficient_position !== want.position)
               report("deficient_position", 64'(rsp_deficient_position), 64'(want.position));
            if (rsp_interval_total !== want.total)
               report("interval_total", rsp_interval_total, want.total);
            if (rsp_overflow !== want.overflow)
               report("overflow", 64'(rsp_overflow), 64'(want.overflow));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic settle();
      repeat (2) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [WORD_W-1:0] value);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_we <= 0;
      if (idx == REG_BASE) begin
         cfg_base = value[31:0];
         split_limit();
      end else if (idx == REG_LIMIT) begin
         cfg_limit = value;
         split_limit();
      end
      settle();
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending_items.size() > 0 || expected_results.size() > 0 || start)
         @(posedge clock);
   endtask

   task automatic push_item(logic [1:0] m, logic [WORD_W-1:0] x);
      digit_item_type it;
      it.mode = m;
      it.operand = x;
      pending_items.insert(pending_items.size(), it);
   endtask

   function automatic logic [WORD_W-1:0] wide_random();
      return {$urandom, $urandom};
   endfunction

   task automatic push_random_item();
      logic [WORD_W-1:0] v;
      logic [WORD_W-1:0] pw;
      logic [1:0] m;
      m = 2'($urandom_range(3));
      if ($urandom_range(99) < 30) begin
         v = wide_random();
      end else if (m == MODE_UNRANK) begin
         v = (span_total == '1) ? wide_random() : wide_random() % (span_total + 1);
      end else begin
         v = 0;
         pw = 1;
         for (int i = 0; i < digit_total; i++) begin
            v = v + {32'd0, 32'($urandom_range(limit_digit[i], 0))} * pw;
            pw = pw * radix_of();
         end
      end
      push_item(m, v);
   endtask

   initial begin
      int made;
      cfg_base = 2;
      cfg_limit = 0;
      split_limit();
      repeat (5) @(posedge clock);
      reset <= 0;
      settle();

      // Reset setting: zero limit, a single digit.
      for (int m = 0; m < 4; m++) begin
         push_item(2'(m), 64'd0);
         push_item(2'(m), '1);
      end
      push_item(MODE_SUCC, 64'h8000_0000_0000_0000);
      drain();

      write_reg(REG_BASE, 64'd0);
      write_reg(REG_LIMIT, '1);
      push_item(MODE_RANK, '1);
      push_item(MODE_UNRANK, '1);
      push_item(MODE_SUCC, 64'h5555_5555_5555_5555);
      drain();

      write_reg(REG_BASE, 64'hFFFF_FFFF_FFFF_FFFF);
      push_item(MODE_RANK, '1);
      push_item(MODE_UNRANK, '1);
      push_item(MODE_SUCC, '1);
      push_item(2'd3, 64'h0123_4567_89AB_CDEF);
      drain();

      write_reg(2'd3, 64'd7);
      write_reg(REG_BASE, 64'd1);
      write_reg(REG_LIMIT, 64'd0);
      push_item(MODE_SUCC, 64'd5);
      push_item(MODE_UNRANK, 64'd9);
      drain();

      write_reg(REG_BASE, 64'd3);
      write_reg(REG_LIMIT, 64'd12345);
      push_item(MODE_SUCC, '1);
      push_item(MODE_RANK, 64'd12345);
      push_item(MODE_UNRANK, 64'd0);
      drain();

      made = 0;
      while (made < 120) begin
         if ($urandom_range(1)) begin
            write_reg(REG_BASE, {32'd0, 32'($urandom_range(16, 2))});
            write_reg(REG_LIMIT, {48'd0, 16'($urandom)});
         end else begin
            write_reg(REG_BASE, {32'd0, $urandom | 32'h0010_0000});
            write_reg(REG_LIMIT, wide_random() >> $urandom_range(40));
         end
         for (int i = 0; i < 10; i++) push_random_item();
         made += 10;
         if (made == 70) begin
            // Hold the sender back until every prediction has been met.
            drain();
         end
         for (int i = 0; i < 10; i++) push_random_item();
         made += 10;
         drain();
      end

      repeat (200) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
